// ----- rtl/tsp_pkg.sv -----
// Shared types and constants for the two-camera timestamp pairer.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package tsp_pkg;

    // Field widths of the frame and result words
    localparam int TS_W    = 63;
    localparam int UNC_W   = 32;
    localparam int TAG_W   = 16;
    localparam int TOL_W   = 32;
    localparam int LIMIT_W = 5;
    localparam int CNT32_W = 32;
    localparam int SKEW_W  = 64;

    // APB register file
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [TOL_W-1:0]   TOL_RESET   = 32'd1_000_000;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd8;

    typedef enum logic [0:0] {
        REG_TOLERANCE = 1'b0,
        REG_LIMIT     = 1'b1
    } reg_idx_t;

    // One pending frame as held in the store
    typedef struct packed {
        logic [TS_W-1:0]  ts;
        logic [UNC_W-1:0] unc;
        logic [TAG_W-1:0] tag;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAIL_RD,
        ST_TAIL_CHK,
        ST_PUSH,
        ST_TRIM,
        ST_LOOP,
        ST_HEAD_A,
        ST_HEAD_B,
        ST_CALC,
        ST_SUM,
        ST_DECIDE,
        ST_DONE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic rd_tail;
        logic chk_tail;
        logic push;
        logic trim_pop;
        logic rd_a;
        logic rd_b;
        logic calc;
        logic sum;
        logic take_pair;
        logic drop_head;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic over_limit;
        logic both_ready;
        logic match;
        logic paired;
    } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/tsp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module tsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- rtl/tsp_ctrl.sv -----
// Sequencer of the pairer: walks one frame word through check, push, trim and
// the head-compare loop. Depends on tsp_pkg.
`default_nettype none

module tsp_ctrl
    import tsp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire dp_status_t status,
    output ctrl_cmd_t       cmd,
    output logic            busy,
    output logic            result_valid
);

    state_t state_reg;
    state_t state_next;
    logic   take;

    assign take = start && !busy;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE, ST_DONE:
            begin
                state_next = take ? ST_TAIL_RD : ST_IDLE;
            end
            ST_TAIL_RD:  state_next = ST_TAIL_CHK;
            ST_TAIL_CHK: state_next = ST_PUSH;
            ST_PUSH:     state_next = ST_TRIM;
            ST_TRIM:
            begin
                state_next = status.over_limit ? ST_TRIM : ST_LOOP;
            end
            ST_LOOP:
            begin
                state_next = status.both_ready ? ST_HEAD_A : ST_DONE;
            end
            ST_HEAD_A:   state_next = ST_HEAD_B;
            ST_HEAD_B:   state_next = ST_CALC;
            ST_CALC:     state_next = ST_SUM;
            ST_SUM:      state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                // a second match after a pair ends the loop
                state_next = (status.match && status.paired) ? ST_DONE : ST_LOOP;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd          = '0;
        busy         = 1'b1;
        result_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy       = 1'b0;
                cmd.accept = take;
            end
            ST_DONE:
            begin
                busy         = 1'b0;
                result_valid = 1'b1;
                cmd.accept   = take;
            end
            ST_TAIL_RD:  cmd.rd_tail  = 1'b1;
            ST_TAIL_CHK: cmd.chk_tail = 1'b1;
            ST_PUSH:     cmd.push     = 1'b1;
            ST_TRIM:     cmd.trim_pop = status.over_limit;
            ST_LOOP:     ;
            ST_HEAD_A:   cmd.rd_a     = 1'b1;
            ST_HEAD_B:   cmd.rd_b     = 1'b1;
            ST_CALC:     cmd.calc     = 1'b1;
            ST_SUM:      cmd.sum      = 1'b1;
            ST_DECIDE:
            begin
                cmd.take_pair = status.match && !status.paired;
                cmd.drop_head = !status.match;
            end
            default:     ;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/tsp_datapath.sv -----
// Datapath of the pairer: two ring FIFOs in one frame store, head compare,
// pair and drop counters and the result word. Depends on tsp_pkg, tsp_ram.
`default_nettype none

module tsp_datapath
    import tsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire ctrl_cmd_t                cmd,
    output dp_status_t                    status,
    input  wire logic [TOL_W-1:0]         tolerance_ns,
    input  wire logic [LIMIT_W-1:0]       queue_limit,
    input  wire logic                     camera,
    input  wire logic [TS_W-1:0]          timestamp_ns,
    input  wire logic [UNC_W-1:0]         uncertainty_ns,
    input  wire logic [TAG_W-1:0]         frame_tag,
    output logic                          pair_valid,
    output logic [TAG_W-1:0]              tag_first,
    output logic [TAG_W-1:0]              tag_second,
    output logic [CNT32_W-1:0]            pair_sequence,
    output logic signed [SKEW_W-1:0]      skew_ns,
    output logic [CNT32_W-1:0]            unmatched_count
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int AW    = $clog2(2 * QUEUE_DEPTH);
    localparam int LIM_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

    // Ring position head + off, off below the depth
    function automatic logic [PTR_W-1:0] ring_slot(input logic [PTR_W-1:0] head,
                                                  input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Camera 1 uses the upper half of the store
    function automatic logic [AW-1:0] mem_addr(input logic cam, input logic [PTR_W-1:0] s);
        return cam ? (AW'(QUEUE_DEPTH) + AW'(s)) : AW'(s);
    endfunction

    // Latched frame word
    logic              cam_reg;
    logic [TS_W-1:0]   ts_reg;
    logic [UNC_W-1:0]  unc_reg;
    logic [TAG_W-1:0]  tag_reg;

    // Queue state
    logic [PTR_W-1:0]  head_reg  [2];
    logic [PTR_W-1:0]  head_next [2];
    logic [CNT_W-1:0]  count_reg  [2];
    logic [CNT_W-1:0]  count_next [2];

    // Head compare pipeline
    logic [TS_W-1:0]   a_ts_reg;
    logic [UNC_W-1:0]  a_unc_reg;
    logic [TAG_W-1:0]  a_tag_reg;
    logic [TAG_W-1:0]  b_tag_reg;
    logic [SKEW_W-1:0] diff_reg;
    logic [TS_W-1:0]   mag_reg;
    logic [UNC_W:0]    usum_reg;
    logic              a_earlier_reg;
    logic              match_reg;

    // Counters and result word
    logic                 paired_reg;
    logic [CNT32_W-1:0]   pair_cnt_reg;
    logic [CNT32_W-1:0]   drop_cnt_reg;
    logic [CNT32_W-1:0]   drop_cnt_next;
    logic [TAG_W-1:0]     tag_first_reg;
    logic [TAG_W-1:0]     tag_second_reg;
    logic [CNT32_W-1:0]   seq_reg;
    logic [SKEW_W-1:0]    skew_reg;

    // Store port
    logic              we;
    logic [AW-1:0]     waddr;
    logic [AW-1:0]     raddr;
    entry_t            wdata;
    entry_t            rdata;
    logic [$bits(entry_t)-1:0] rdata_raw;

    // Helpers
    logic [PTR_W-1:0]  cur_head;
    logic [CNT_W-1:0]  cur_count;
    logic [CNT_W-1:0]  tail_off;
    logic              full;
    logic [PTR_W-1:0]  push_head;
    logic [CNT_W-1:0]  push_off;
    logic [LIM_W-1:0]  limit_ext;
    logic [LIM_W-1:0]  limit_eff;
    logic              drop_en;
    logic [CNT_W-1:0]  drop_amt;
    logic [CNT32_W:0]  drop_sum;
    logic              pop_cam;
    logic [SKEW_W-1:0] total;

    assign cur_head  = head_reg[cam_reg];
    assign cur_count = count_reg[cam_reg];
    assign tail_off  = (cur_count == '0) ? '0 : cur_count - 1'b1;
    assign full      = (cur_count == CNT_W'(QUEUE_DEPTH));
    assign push_head = full ? next_ptr(cur_head) : cur_head;
    assign push_off  = full ? CNT_W'(QUEUE_DEPTH - 1) : cur_count;
    assign pop_cam   = !a_earlier_reg;

    // Effective limit, clipped to the queue depth
    assign limit_ext = LIM_W'(queue_limit);
    assign limit_eff = (limit_ext > LIM_W'(QUEUE_DEPTH)) ? LIM_W'(QUEUE_DEPTH) : limit_ext;

    assign status.over_limit = LIM_W'(cur_count) > limit_eff;
    assign status.both_ready = (count_reg[0] != '0) && (count_reg[1] != '0);
    assign status.match      = match_reg;
    assign status.paired     = paired_reg;

    // Frame store
    assign wdata.ts  = ts_reg;
    assign wdata.unc = unc_reg;
    assign wdata.tag = tag_reg;
    assign rdata     = entry_t'(rdata_raw);

    tsp_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (2 * QUEUE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    // Read address select
    always_comb
    begin
        priority if (cmd.rd_a)
        begin
            raddr = mem_addr(1'b0, head_reg[0]);
        end
        else if (cmd.rd_b)
        begin
            raddr = mem_addr(1'b1, head_reg[1]);
        end
        else
        begin
            raddr = mem_addr(cam_reg, ring_slot(cur_head, tail_off));
        end
    end

    // Queue updates, store writes and drop amounts
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        we         = 1'b0;
        waddr      = mem_addr(cam_reg, ring_slot(push_head, push_off));
        drop_en    = 1'b0;
        drop_amt   = '0;

        // flush on a timestamp that does not move forward
        if (cmd.chk_tail && (cur_count != '0) && (ts_reg <= rdata.ts))
        begin
            count_next[cam_reg] = '0;
            drop_en             = 1'b1;
            drop_amt            = cur_count;
        end

        // push, dropping the oldest when the ring is full
        if (cmd.push)
        begin
            we                  = 1'b1;
            head_next[cam_reg]  = push_head;
            count_next[cam_reg] = full ? cur_count : cur_count + 1'b1;
            if (full)
            begin
                drop_en  = 1'b1;
                drop_amt = CNT_W'(1);
            end
        end

        if (cmd.trim_pop)
        begin
            head_next[cam_reg]  = next_ptr(cur_head);
            count_next[cam_reg] = cur_count - 1'b1;
            drop_en             = 1'b1;
            drop_amt            = CNT_W'(1);
        end

        if (cmd.take_pair)
        begin
            head_next[0]  = next_ptr(head_reg[0]);
            head_next[1]  = next_ptr(head_reg[1]);
            count_next[0] = count_reg[0] - 1'b1;
            count_next[1] = count_reg[1] - 1'b1;
        end

        // earlier head goes; on a tie the camera 1 head
        if (cmd.drop_head)
        begin
            head_next[pop_cam]  = next_ptr(head_reg[pop_cam]);
            count_next[pop_cam] = count_reg[pop_cam] - 1'b1;
            drop_en             = 1'b1;
            drop_amt            = CNT_W'(1);
        end
    end

    // Saturating unmatched counter
    assign drop_sum      = {1'b0, drop_cnt_reg} + (CNT32_W + 1)'(drop_amt);
    assign drop_cnt_next = drop_sum[CNT32_W] ? '1 : drop_sum[CNT32_W-1:0];

    // Skew plus both uncertainties
    assign total = SKEW_W'(mag_reg) + SKEW_W'(usum_reg);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[0]  <= '0;
            head_reg[1]  <= '0;
            count_reg[0] <= '0;
            count_reg[1] <= '0;
            pair_cnt_reg <= '0;
            drop_cnt_reg <= '0;
            paired_reg   <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            if (drop_en)
            begin
                drop_cnt_reg <= drop_cnt_next;
            end
            if (cmd.accept)
            begin
                paired_reg <= 1'b0;
            end
            else if (cmd.take_pair)
            begin
                paired_reg   <= 1'b1;
                pair_cnt_reg <= pair_cnt_reg + 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            cam_reg        <= camera;
            ts_reg         <= timestamp_ns;
            unc_reg        <= uncertainty_ns;
            tag_reg        <= frame_tag;
            tag_first_reg  <= '0;
            tag_second_reg <= '0;
            seq_reg        <= '0;
            skew_reg       <= '0;
        end
        if (cmd.rd_b)
        begin
            a_ts_reg  <= rdata.ts;
            a_unc_reg <= rdata.unc;
            a_tag_reg <= rdata.tag;
        end
        if (cmd.calc)
        begin
            b_tag_reg     <= rdata.tag;
            diff_reg      <= {1'b0, a_ts_reg} - {1'b0, rdata.ts};
            mag_reg       <= (a_ts_reg >= rdata.ts) ? (a_ts_reg - rdata.ts)
                                                    : (rdata.ts - a_ts_reg);
            usum_reg      <= {1'b0, a_unc_reg} + {1'b0, rdata.unc};
            a_earlier_reg <= a_ts_reg < rdata.ts;
        end
        if (cmd.sum)
        begin
            match_reg <= total <= SKEW_W'(tolerance_ns);
        end
        if (cmd.take_pair)
        begin
            tag_first_reg  <= a_tag_reg;
            tag_second_reg <= b_tag_reg;
            seq_reg        <= pair_cnt_reg + 1'b1;
            skew_reg       <= diff_reg;
        end
    end

    assign pair_valid      = paired_reg;
    assign tag_first       = tag_first_reg;
    assign tag_second      = tag_second_reg;
    assign pair_sequence   = seq_reg;
    assign skew_ns         = signed'(skew_reg);
    assign unmatched_count = drop_cnt_reg;

endmodule

`default_nettype wire

// ----- rtl/two_stream_timestamp_pairer_unit.sv -----
// Top level of the two-camera timestamp pairer: APB registers, controller and
// datapath. Depends on tsp_pkg, tsp_ctrl, tsp_datapath (and tsp_ram below it).
//
//  channel   handshake              payload
//  ------    ---------------------  ---------------------------------------------
//  frame     start / busy           camera, timestamp_ns, uncertainty_ns, frame_tag
//  result    result_valid (strobe)  pair_valid, tag_first, tag_second,
//                                   pair_sequence, skew_ns, unmatched_count
//  config    APB psel/penable       tolerance_ns at 0x0, queue_limit at 0x4
//
// From accept to the result strobe a frame word passes tail read, tail check,
// push and trim (k oldest entries trimmed one a cycle), then m head compares
// (head A, head B, calc, sum, decide, loop), the last without its loop step when
// a second match ends it; heads come in turn from the shared store's one read port.
// The result shows for one cycle; a new start is taken in that same cycle.
// Reset empties both queues and clears both counters; the store is not cleared.
`default_nettype none

module two_stream_timestamp_pairer_unit
    import tsp_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // configuration
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready,
    // frame word
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic                 camera,
    input  wire logic [TS_W-1:0]      timestamp_ns,
    input  wire logic [UNC_W-1:0]     uncertainty_ns,
    input  wire logic [TAG_W-1:0]     frame_tag,
    // result word
    output logic                      result_valid,
    output logic                      pair_valid,
    output logic [TAG_W-1:0]          tag_first,
    output logic [TAG_W-1:0]          tag_second,
    output logic [CNT32_W-1:0]        pair_sequence,
    output logic signed [SKEW_W-1:0]  skew_ns,
    output logic [CNT32_W-1:0]        unmatched_count
);

    logic [TOL_W-1:0]   tolerance_reg;
    logic [LIMIT_W-1:0] limit_reg;
    reg_idx_t           reg_idx;
    logic               cfg_write;
    ctrl_cmd_t          cmd;
    dp_status_t         status;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[2]);
    assign cfg_write = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg <= TOL_RESET;
            limit_reg     <= LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_TOLERANCE: tolerance_reg <= pwdata[TOL_W-1:0];
                REG_LIMIT:     limit_reg     <= pwdata[LIMIT_W-1:0];
                default:       ;
            endcase
        end
    end

    // Register reads
    always_comb
    begin
        unique case (reg_idx)
            REG_TOLERANCE: prdata = APB_DW'(tolerance_reg);
            REG_LIMIT:     prdata = APB_DW'(limit_reg);
            default:       prdata = '0;
        endcase
    end

    tsp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .status       (status),
        .cmd          (cmd),
        .busy         (busy),
        .result_valid (result_valid)
    );

    tsp_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .tolerance_ns    (tolerance_reg),
        .queue_limit     (limit_reg),
        .camera          (camera),
        .timestamp_ns    (timestamp_ns),
        .uncertainty_ns  (uncertainty_ns),
        .frame_tag       (frame_tag),
        .pair_valid      (pair_valid),
        .tag_first       (tag_first),
        .tag_second      (tag_second),
        .pair_sequence   (pair_sequence),
        .skew_ns         (skew_ns),
        .unmatched_count (unmatched_count)
    );

endmodule

`default_nettype wire
